@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the rtl
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SSPQ_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define SSPQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
`define SSPQ_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SSPQ_ASSERT(label, clk, rstn, prop, msg)
`define SSPQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define SSPQ_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

@@ hw/rtl/sspq_pkg.sv @@
// types and constants of the stable sorted priority queue
// no dependencies
package sspq_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned RankW   = 32;
  localparam int unsigned OpW     = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

@@ hw/rtl/sspq_cell.sv @@
// one slot of the sorted chain: holds a value and rank pair
// depends on sspq_pkg
module sspq_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                                     clk_i,
  input  sspq_pkg::cell_ctl_t                      ctl_i,
  input  logic [CNT_W-1:0]                         cnt_i,
  input  logic signed [sspq_pkg::ValueW-1:0]       new_value_i,
  input  logic signed [sspq_pkg::RankW-1:0]        new_rank_i,
  input  logic signed [sspq_pkg::ValueW-1:0]       left_value_i,
  input  logic signed [sspq_pkg::RankW-1:0]        left_rank_i,
  input  logic                                     left_shift_i,
  input  logic signed [sspq_pkg::ValueW-1:0]       right_value_i,
  input  logic signed [sspq_pkg::RankW-1:0]        right_rank_i,
  output logic signed [sspq_pkg::ValueW-1:0]       value_o,
  output logic signed [sspq_pkg::RankW-1:0]        rank_o,
  output logic                                     shift_o
);

  localparam logic [CNT_W-1:0] Idx = CNT_W'(INDEX);

  logic signed [sspq_pkg::ValueW-1:0] value_q, value_d;
  logic signed [sspq_pkg::RankW-1:0]  rank_q, rank_d;
  logic                               occupied;
  logic                               at_end;

  assign occupied = Idx < cnt_i;
  assign at_end   = Idx == cnt_i;
  // new rank strictly lower: this entry moves one slot back
  assign shift_o  = occupied && (new_rank_i < rank_q);

  always_comb begin
    value_d = value_q;
    rank_d  = rank_q;
    if (ctl_i.rem) begin
      value_d = right_value_i;
      rank_d  = right_rank_i;
    end else if (ctl_i.ins) begin
      if (left_shift_i) begin
        value_d = left_value_i;
        rank_d  = left_rank_i;
      end else if (shift_o || at_end) begin
        value_d = new_value_i;
        rank_d  = new_rank_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    rank_q  <= rank_d;
  end

  assign value_o = value_q;
  assign rank_o  = rank_q;

endmodule

@@ hw/rtl/stable_sorted_priority_queue.sv @@
// stable sorted priority queue, min rank first, equal ranks leave in arrival order
// depends on sspq_pkg, sspq_cell and assert_macros.svh
//
// input channel s_axis: one word per operation; tuser carries the operation
// (insert, remove lowest, clear), tdata carries item value and item rank.
// output channel m_axis: exactly one word per operation; tdata carries the
// removed value (zero unless a remove succeeded) and the entry count after the
// operation, tuser carries the status (ok, insert dropped on full, remove on
// empty).
// the entries sit in a row of CAPACITY cells kept in rank order; every cell
// compares the incoming rank with its own in the same cycle and either holds,
// takes its left neighbor, takes the new entry or takes its right neighbor.
// throughput is one operation per cycle unless m_axis stalls, set by that single
// compare and shift step; a result shows on m_axis the cycle after acceptance.
// the result sits in an output register; s_axis_tready stays high while that
// register is empty or being taken, so a stalled receiver holds the input after
// one result is waiting.
// reset empties the queue and the output register; slot contents are not cleared
`include "assert_macros.svh"

module stable_sorted_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // item_value [31:0], item_rank [63:32]
  input  logic [1:0]  s_axis_tuser,   // operation [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // removed_value [31:0], entry_count [36:32], zero
  output logic [1:0]  m_axis_tuser    // status [1:0]
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] Cap = CntW'(CAPACITY);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;
  logic            full, empty;
  sspq_pkg::op_e   op;
  sspq_pkg::cell_ctl_t ctl;
  sspq_pkg::status_e   status;
  logic signed [sspq_pkg::ValueW-1:0] in_value, removed;
  logic signed [sspq_pkg::RankW-1:0]  in_rank;

  logic signed [sspq_pkg::ValueW-1:0] cell_value [CAPACITY];
  logic signed [sspq_pkg::RankW-1:0]  cell_rank  [CAPACITY];
  logic                               cell_shift [CAPACITY];

  logic                             out_valid_q;
  logic signed [sspq_pkg::ValueW-1:0] out_value_q;
  logic [sspq_pkg::CountW-1:0]      out_count_q;
  sspq_pkg::status_e                out_status_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign op       = sspq_pkg::op_e'(s_axis_tuser);
  assign in_value = s_axis_tdata[31:0];
  assign in_rank  = s_axis_tdata[63:32];
  assign full     = cnt_q == Cap;
  assign empty    = cnt_q == '0;

  always_comb begin
    ctl     = '0;
    cnt_d   = cnt_q;
    status  = sspq_pkg::ST_OK;
    removed = '0;
    case (op)
      sspq_pkg::OP_INSERT: begin
        if (full) begin
          status = sspq_pkg::ST_FULL;
        end else begin
          ctl.ins = accept;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      sspq_pkg::OP_REMOVE: begin
        if (empty) begin
          status = sspq_pkg::ST_EMPTY;
        end else begin
          ctl.rem = accept;
          cnt_d   = cnt_q - 1'b1;
          removed = cell_value[0];
        end
      end
      sspq_pkg::OP_CLEAR: begin
        cnt_d = '0;
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [sspq_pkg::ValueW-1:0] left_value, right_value;
    logic signed [sspq_pkg::RankW-1:0]  left_rank, right_rank;
    logic                               left_shift;

    if (i == 0) begin : g_head
      assign left_value = '0;
      assign left_rank  = '0;
      assign left_shift = 1'b0;
    end else begin : g_mid
      assign left_value = cell_value[i-1];
      assign left_rank  = cell_rank[i-1];
      assign left_shift = cell_shift[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = cell_value[i];
      assign right_rank  = cell_rank[i];
    end else begin : g_body
      assign right_value = cell_value[i+1];
      assign right_rank  = cell_rank[i+1];
    end

    sspq_cell #(
      .INDEX (i),
      .CNT_W (CntW)
    ) u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .cnt_i         (cnt_q),
      .new_value_i   (in_value),
      .new_rank_i    (in_rank),
      .left_value_i  (left_value),
      .left_rank_i   (left_rank),
      .left_shift_i  (left_shift),
      .right_value_i (right_value),
      .right_rank_i  (right_rank),
      .value_o       (cell_value[i]),
      .rank_o        (cell_rank[i]),
      .shift_o       (cell_shift[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_value_q  <= removed;
      out_status_q <= status;
      out_count_q  <= sspq_pkg::CountW'(cnt_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_count_q, out_value_q};
  assign m_axis_tuser  = out_status_q;

  `SSPQ_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= Cap, "entry count above capacity")
  `SSPQ_ASSERT_NXT(a_ins_grows, clk_i, rst_ni, ctl.ins, cnt_q == $past(cnt_q) + 1'b1, "insert did not grow count")
  `SSPQ_ASSERT_IMP(a_head_order, clk_i, rst_ni, cnt_q >= CntW'(2), cell_rank[0] <= cell_rank[1], "head entries out of rank order")
  `SSPQ_ASSERT_IMP(a_one_op, clk_i, rst_ni, ctl.ins || ctl.rem, accept && !(ctl.ins && ctl.rem), "cell control without a single accepted operation")

endmodule
